### src/rif_pkg.sv
package rif_pkg;

    localparam int MAX_POLES   = 8;
    localparam int TAPS        = MAX_POLES + 1;
    localparam int COEF_DEPTH  = 2 * TAPS;
    localparam int CA_W        = $clog2(COEF_DEPTH);
    localparam int POS_W       = $clog2(TAPS);
    localparam int ORDER_W     = 4;
    localparam int IDX_W       = 4;
    localparam int COEF_W      = 32;
    localparam int SMP_W       = 16;
    localparam int FRAC_W      = 24;
    localparam int PROD_W      = COEF_W + SMP_W;
    localparam int ACC_W       = PROD_W + $clog2(2 * MAX_POLES + 1);
    localparam int INT_W       = ACC_W - FRAC_W;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);

    typedef logic [1:0] t_req_type;

    localparam t_req_type REQ_SAMPLE = 2'd0;
    localparam t_req_type REQ_LOAD_A = 2'd1;
    localparam t_req_type REQ_LOAD_B = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

### src/rif_if.sv
interface rif_req_if;
    logic                                       valid;
    logic                                       ready;
    rif_pkg::t_req_type                         req_type;
    logic        [rif_pkg::IDX_W-1:0]           coef_index;
    logic signed [rif_pkg::COEF_W-1:0]          coef_value;
    logic signed [rif_pkg::SMP_W-1:0]           sample_in;

    modport source (output valid, req_type, coef_index, coef_value, sample_in, input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, sample_in, output ready);
endinterface

interface rif_rsp_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [rif_pkg::SMP_W-1:0]           sample_out;
    logic                                       saturated;

    modport source (output valid, sample_out, saturated, input ready);
    modport sink   (input valid, sample_out, saturated, output ready);
endinterface

### src/recursive_iir_filter_core.sv
// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    req_type, coef_index, coef_value, sample_in
// o_rsp     out  valid / ready    sample_out, saturated
// i_cfg     in   i_cfg_we         i_cfg_wdata (filter order)
//
// A coefficient load is written from the accepted request. A sample runs through issue steps
// on one shared 32x16 multiplier fed by the coefficient and history memories, a drain step
// until the multiplier pipeline empties, and a finish step. The next transaction is taken
// once the core is back in idle. Reset is synchronous; per-entry valid bits make all tables
// read as zero at once. A stalled o_rsp holds the finished result; the next sample still
// enters and waits in its last step until the output register frees.
module recursive_iir_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rif_pkg::ORDER_W-1:0]       i_cfg_wdata,
    rif_req_if.sink                           i_req,
    rif_rsp_if.source                         o_rsp
);

    rif_pkg::t_state r_state, n_state;

    logic [rif_pkg::ORDER_W-1:0] r_filter_order;

    logic signed [rif_pkg::COEF_W-1:0]  r_coef_mem [rif_pkg::COEF_DEPTH];
    logic [rif_pkg::COEF_DEPTH-1:0]     r_coef_vld;
    logic [2*rif_pkg::SMP_W-1:0]        r_hist_mem [rif_pkg::TAPS];
    logic [rif_pkg::TAPS-1:0]           r_hist_vld;
    logic [rif_pkg::POS_W-1:0]          r_ring_pos;

    logic signed [rif_pkg::SMP_W-1:0]   r_x;
    logic [rif_pkg::POS_W-1:0]          r_k;
    logic                               r_phase;
    logic [rif_pkg::POS_W-1:0]          r_pos;

    logic                               r_rd_v;
    logic                               r_rd_use_x;
    logic                               r_rd_phase;
    logic signed [rif_pkg::COEF_W-1:0]  r_coef_q;
    logic                               r_coef_q_ok;
    logic [2*rif_pkg::SMP_W-1:0]        r_hist_q;
    logic                               r_hist_q_ok;

    logic                               r_prod_v;
    logic signed [rif_pkg::PROD_W-1:0]  r_prod;
    logic signed [rif_pkg::ACC_W-1:0]   r_acc;

    logic                               r_out_vld;
    logic signed [rif_pkg::SMP_W-1:0]   r_out_smp;
    logic                               r_out_sat;

    logic [rif_pkg::POS_W-1:0]          order_eff;
    logic [rif_pkg::POS_W-1:0]          pos_start;
    logic                               accept;
    logic                               sample_go;
    logic                               coef_we;
    logic [rif_pkg::CA_W-1:0]           coef_waddr;
    logic [rif_pkg::CA_W-1:0]           coef_raddr;
    logic                               issue;
    logic                               last_issue;
    logic                               fin_fire;
    logic signed [rif_pkg::COEF_W-1:0]  coef_op;
    logic signed [rif_pkg::SMP_W-1:0]   hist_op;
    logic signed [rif_pkg::PROD_W-1:0]  prod_c;
    logic signed [rif_pkg::INT_W-1:0]   acc_int;
    logic                               sat_hi;
    logic                               sat_lo;
    logic signed [rif_pkg::SMP_W-1:0]   y_c;

    assign order_eff = (int'(r_filter_order) > rif_pkg::MAX_POLES)
                     ? rif_pkg::POS_W'(rif_pkg::MAX_POLES)
                     : rif_pkg::POS_W'(r_filter_order);
    assign pos_start = (r_ring_pos <= order_eff) ? r_ring_pos : '0;

    assign accept     = i_req.valid && i_req.ready;
    assign sample_go  = accept && (i_req.req_type == rif_pkg::REQ_SAMPLE);
    assign coef_we    = accept
                     && (i_req.req_type == rif_pkg::REQ_LOAD_A
                         || i_req.req_type == rif_pkg::REQ_LOAD_B)
                     && (int'(i_req.coef_index) <= rif_pkg::MAX_POLES);
    assign coef_waddr = (i_req.req_type == rif_pkg::REQ_LOAD_B)
                      ? rif_pkg::CA_W'(rif_pkg::TAPS) + rif_pkg::CA_W'(i_req.coef_index)
                      : rif_pkg::CA_W'(i_req.coef_index);

    assign issue      = (r_state == rif_pkg::S_ISSUE);
    assign coef_raddr = r_phase ? rif_pkg::CA_W'(rif_pkg::TAPS) + rif_pkg::CA_W'(r_k)
                                : rif_pkg::CA_W'(r_k);
    // tap zero uses a[0] only; later taps end on their feedback product
    assign last_issue = (r_k == order_eff) && (r_phase || (r_k == '0));
    assign fin_fire   = (r_state == rif_pkg::S_FINISH) && (!r_out_vld || o_rsp.ready);

    // Multiply stage: unwritten entries read as zero
    assign coef_op = r_coef_q_ok ? r_coef_q : '0;
    always_comb begin
        if (r_rd_use_x) begin
            hist_op = r_x;
        end else if (!r_hist_q_ok) begin
            hist_op = '0;
        end else if (r_rd_phase) begin
            hist_op = r_hist_q[rif_pkg::SMP_W-1:0];
        end else begin
            hist_op = r_hist_q[2*rif_pkg::SMP_W-1:rif_pkg::SMP_W];
        end
    end
    assign prod_c = coef_op * hist_op;

    // Accumulator starts at half an LSB, so the floor below rounds
    assign acc_int = r_acc[rif_pkg::ACC_W-1:rif_pkg::FRAC_W];
    assign sat_hi  = acc_int > signed'(rif_pkg::INT_W'(32767));
    assign sat_lo  = acc_int < signed'(rif_pkg::INT_W'(-32768));
    always_comb begin
        if (sat_hi) begin
            y_c = 16'sh7FFF;
        end else if (sat_lo) begin
            y_c = 16'sh8000;
        end else begin
            y_c = acc_int[rif_pkg::SMP_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        case (r_state)
            rif_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (sample_go) begin
                    n_state = rif_pkg::S_ISSUE;
                end
            end
            rif_pkg::S_ISSUE: begin
                if (last_issue) begin
                    n_state = rif_pkg::S_DRAIN;
                end
            end
            rif_pkg::S_DRAIN: begin
                if (!r_rd_v && !r_prod_v) begin
                    n_state = rif_pkg::S_FINISH;
                end
            end
            rif_pkg::S_FINISH: begin
                if (fin_fire) begin
                    n_state = rif_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rif_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rif_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_order <= rif_pkg::ORDER_RESET;
            r_coef_vld     <= '0;
            r_hist_vld     <= '0;
            r_ring_pos     <= '0;
            r_rd_v         <= 1'b0;
            r_prod_v       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_filter_order <= i_cfg_wdata;
            end
            if (coef_we) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
            if (fin_fire) begin
                r_hist_vld[r_pos] <= 1'b1;
                r_ring_pos        <= r_pos;
            end
            r_rd_v   <= issue;
            r_prod_v <= r_rd_v;
            if (fin_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= i_req.coef_value;
        end
        r_coef_q    <= r_coef_mem[coef_raddr];
        r_coef_q_ok <= r_coef_vld[coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_hist_mem[r_pos] <= {r_x, y_c};
        end
        r_hist_q    <= r_hist_mem[r_pos];
        r_hist_q_ok <= r_hist_vld[r_pos];
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        r_rd_use_x <= (r_k == '0);
        r_rd_phase <= r_phase;
        r_prod     <= prod_c;
        if (sample_go) begin
            r_x     <= i_req.sample_in;
            r_k     <= '0;
            r_phase <= 1'b0;
            r_pos   <= pos_start;
            r_acc   <= rif_pkg::ACC_W'(1 << (rif_pkg::FRAC_W - 1));
        end else begin
            if (issue) begin
                if (r_k == '0) begin
                    r_k <= rif_pkg::POS_W'(1);
                end else if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_k     <= r_k + rif_pkg::POS_W'(1);
                    r_pos   <= (r_pos == order_eff) ? '0 : r_pos + rif_pkg::POS_W'(1);
                end
            end
            if (r_prod_v) begin
                r_acc <= r_acc + rif_pkg::ACC_W'(r_prod);
            end
        end
        if (fin_fire) begin
            r_out_smp <= y_c;
            r_out_sat <= sat_hi || sat_lo;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.sample_out = r_out_smp;
    assign o_rsp.saturated  = r_out_sat;

    a_rsp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == rif_pkg::S_FINISH)
        else $error("result raised outside the finish step");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rif_pkg::S_IDLE) |-> (!r_rd_v && !r_prod_v))
        else $error("multiply pipeline busy while idle");

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rif_pkg::S_ISSUE) |-> (r_pos <= order_eff && r_k <= order_eff))
        else $error("ring pointer or tap beyond filter order");

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |-> (r_out_smp == 16'sh7FFF || r_out_smp == 16'sh8000))
        else $error("saturation flag without clipped sample");

endmodule
